@@ rtl/core/mnps_pkg.sv @@
// mnps_pkg: shared constants, types and widths for the nearest pose search
// no dependencies; used by mnps_cell, mnps_dist and masked_nearest_pose_search
`timescale 1ns / 1ps

package mnps_pkg;

    // table size and derived widths
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W       = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

    // payload widths fixed by the field list
    localparam int NCOMP       = 6;
    localparam int COMP_W      = 16;
    localparam int SQ_W        = 32;
    localparam int PAIR_W      = SQ_W + 1;
    localparam int DIST_W      = 35;
    localparam int OUT_DIST_W  = 37;
    localparam int OUT_IDX_W   = 6;
    localparam int COUNT_W     = 7;

    // input kind codes
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // six components: pos x/y/z then dir x/y/z
    typedef logic [NCOMP-1:0][COMP_W-1:0] t_vec;

    typedef struct packed {
        t_vec comp;
        logic cand;
    } t_entry;

    // control carried alongside the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

@@ rtl/core/mnps_cell.sv @@
// mnps_cell: one table slot of the rotating entry ring
// depends on mnps_pkg
`timescale 1ns / 1ps

module mnps_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic           i_load,
    input  mnps_pkg::t_entry i_load_entry,
    input  mnps_pkg::t_entry i_next,
    output mnps_pkg::t_entry o_entry
);

    mnps_pkg::t_vec r_comp;
    logic           r_cand;

    // component payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_comp <= i_load_entry.comp;
        end else if (i_shift) begin
            r_comp <= i_next.comp;
        end
    end

    // candidate bit, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= 1'b0;
        end else if (i_load) begin
            r_cand <= i_load_entry.cand;
        end else if (i_shift) begin
            r_cand <= i_next.cand;
        end
    end

    assign o_entry.comp = r_comp;
    assign o_entry.cand = r_cand;

endmodule

@@ rtl/core/mnps_dist.sv @@
// mnps_dist: four stage squared distance pipeline (difference, square, pair sum, total)
// depends on mnps_pkg
`timescale 1ns / 1ps

module mnps_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mnps_pkg::t_vec                i_vec,
    input  mnps_pkg::t_vec                i_qvec,
    input  mnps_pkg::t_tag                i_tag,
    output mnps_pkg::t_tag                o_tag,
    output logic [mnps_pkg::DIST_W-1:0]   o_dist
);

    logic signed [mnps_pkg::COMP_W:0]     n_diff [mnps_pkg::NCOMP];
    logic signed [mnps_pkg::COMP_W:0]     r_diff [mnps_pkg::NCOMP];
    logic signed [2*mnps_pkg::COMP_W+1:0] n_prod [mnps_pkg::NCOMP];
    logic [mnps_pkg::SQ_W-1:0]            r_sq   [mnps_pkg::NCOMP];
    logic [mnps_pkg::PAIR_W-1:0]          r_pair [mnps_pkg::NCOMP/2];
    logic [mnps_pkg::DIST_W-1:0]          n_sum;
    logic [mnps_pkg::DIST_W-1:0]          r_sum;
    mnps_pkg::t_tag                       r_tag_a;
    mnps_pkg::t_tag                       r_tag_b;
    mnps_pkg::t_tag                       r_tag_c;
    mnps_pkg::t_tag                       r_tag_d;

    // sign extended component differences
    always_comb begin
        for (int k = 0; k < mnps_pkg::NCOMP; k++) begin
            n_diff[k] = $signed({i_vec[k][mnps_pkg::COMP_W-1], i_vec[k]})
                      - $signed({i_qvec[k][mnps_pkg::COMP_W-1], i_qvec[k]});
        end
    end

    // one squarer per component, independent of each other
    always_comb begin
        for (int k = 0; k < mnps_pkg::NCOMP; k++) begin
            n_prod[k] = r_diff[k] * r_diff[k];
        end
    end

    // total of the pair sums
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < mnps_pkg::NCOMP/2; k++) begin
            n_sum = n_sum + mnps_pkg::DIST_W'(r_pair[k]);
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < mnps_pkg::NCOMP; k++) begin
            r_diff[k] <= n_diff[k];
            r_sq[k]   <= n_prod[k][mnps_pkg::SQ_W-1:0];
        end
        for (int k = 0; k < mnps_pkg::NCOMP/2; k++) begin
            r_pair[k] <= mnps_pkg::PAIR_W'(r_sq[2*k]) + mnps_pkg::PAIR_W'(r_sq[2*k+1]);
        end
        r_sum <= n_sum;
    end

    // tag stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
            r_tag_d <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
            r_tag_d <= r_tag_c;
        end
    end

    assign o_tag  = r_tag_d;
    assign o_dist = r_sum;

endmodule

@@ rtl/core/masked_nearest_pose_search.sv @@
// masked_nearest_pose_search: top level, ring of entry cells, query sequencer, result register
// depends on mnps_pkg, mnps_cell, mnps_dist
`timescale 1ns / 1ps
//
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall  kind, entry_index, pos/dir x y z, is_candidate,
//                                              query_index
//  out      output     o_out_valid/i_out_stall found, best_index, best_distance_sq
//  cfg      input      i_cfg_valid/o_cfg_ready entry_count
//
//  a load transaction does not stall the input; loads can be accepted on consecutive cycles
//  a query holds o_in_stall high while the sequencer rotates the ring once to fetch the
//  query entry, once more to stream every entry through the four stage distance pipeline,
//  then drains the pipeline and loads the result register
//  a stalled result holds the sequencer in its done state until the result register frees
//  reset is synchronous, active low; it clears control state and the candidate bits

module masked_nearest_pose_search (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_kind,
    input  logic [5:0]                             i_entry_index,
    input  logic signed [mnps_pkg::COMP_W-1:0]     i_pos_x,
    input  logic signed [mnps_pkg::COMP_W-1:0]     i_pos_y,
    input  logic signed [mnps_pkg::COMP_W-1:0]     i_pos_z,
    input  logic signed [mnps_pkg::COMP_W-1:0]     i_dir_x,
    input  logic signed [mnps_pkg::COMP_W-1:0]     i_dir_y,
    input  logic signed [mnps_pkg::COMP_W-1:0]     i_dir_z,
    input  logic                                   i_is_candidate,
    input  logic [5:0]                             i_query_index,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_found,
    output logic [mnps_pkg::OUT_IDX_W-1:0]         o_best_index,
    output logic [mnps_pkg::OUT_DIST_W-1:0]        o_best_distance_sq,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mnps_pkg::COUNT_W-1:0]           i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [mnps_pkg::IDX_W-1:0] STEP_LAST = mnps_pkg::IDX_W'(mnps_pkg::MAX_ENTRIES - 1);

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic [mnps_pkg::IDX_W-1:0]        r_step;
    logic [mnps_pkg::COUNT_W-1:0]      r_count;
    logic [5:0]                        r_q;
    mnps_pkg::t_vec                    r_qvec;
    logic                              r_found;
    logic [mnps_pkg::IDX_W-1:0]        r_best_idx;
    logic [mnps_pkg::DIST_W-1:0]       r_best_d;
    logic                              r_out_valid;
    logic                              r_out_found;
    logic [mnps_pkg::OUT_IDX_W-1:0]    r_out_idx;
    logic [mnps_pkg::OUT_DIST_W-1:0]   r_out_dist;

    logic                              w_in_acc;
    logic                              w_load;
    logic                              w_query;
    logic                              w_shift;
    logic                              w_last_step;
    logic                              w_out_free;
    logic [mnps_pkg::CMP_W-1:0]        w_eff_count;
    logic [mnps_pkg::CMP_W-1:0]        w_step_x;
    logic [mnps_pkg::CMP_W-1:0]        w_q_x;
    logic [mnps_pkg::CMP_W-1:0]        w_best_x;
    logic                              w_in_range;
    mnps_pkg::t_entry                  w_load_entry;
    mnps_pkg::t_entry                  w_cell [mnps_pkg::MAX_ENTRIES];
    mnps_pkg::t_tag                    w_tag_in;
    mnps_pkg::t_tag                    w_tag_out;
    logic [mnps_pkg::DIST_W-1:0]       w_dist;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_load      = w_in_acc && (i_kind == mnps_pkg::KIND_LOAD);
    assign w_query     = w_in_acc && (i_kind == mnps_pkg::KIND_QUERY);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // ring rotates during both passes of a query
    assign w_shift     = (r_state == S_FETCH) || (r_state == S_SCAN);
    assign w_last_step = (r_step == STEP_LAST);

    // entry built from a load transaction
    assign w_load_entry.comp[0] = i_pos_x;
    assign w_load_entry.comp[1] = i_pos_y;
    assign w_load_entry.comp[2] = i_pos_z;
    assign w_load_entry.comp[3] = i_dir_x;
    assign w_load_entry.comp[4] = i_dir_y;
    assign w_load_entry.comp[5] = i_dir_z;
    assign w_load_entry.cand    = i_is_candidate;

    // ring of cells, cell g takes the contents of cell g+1
    for (genvar g = 0; g < mnps_pkg::MAX_ENTRIES; g++) begin : g_cell
        logic w_cell_load;
        assign w_cell_load = w_load &&
            (mnps_pkg::CMP_W'(i_entry_index) == mnps_pkg::CMP_W'(g));
        mnps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (w_shift),
            .i_load       (w_cell_load),
            .i_load_entry (w_load_entry),
            .i_next       (w_cell[(g + 1) % mnps_pkg::MAX_ENTRIES]),
            .o_entry      (w_cell[g])
        );
    end

    // effective count and index compares
    always_comb begin
        w_eff_count = mnps_pkg::CMP_W'(r_count);
        if (w_eff_count > mnps_pkg::CMP_W'(mnps_pkg::MAX_ENTRIES)) begin
            w_eff_count = mnps_pkg::CMP_W'(mnps_pkg::MAX_ENTRIES);
        end
        w_step_x   = mnps_pkg::CMP_W'(r_step);
        w_q_x      = mnps_pkg::CMP_W'(r_q);
        w_in_range = (w_q_x < w_eff_count);
        w_best_x   = mnps_pkg::CMP_W'(r_best_idx);
    end

    // tag for the entry at the head of the ring
    always_comb begin
        w_tag_in       = '0;
        w_tag_in.idx   = r_step;
        if (r_state == S_SCAN) begin
            w_tag_in.valid = w_in_range && (w_step_x < w_eff_count) &&
                             (w_step_x != w_q_x) && w_cell[0].cand;
            w_tag_in.last  = w_last_step;
        end
    end

    mnps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (w_cell[0].comp),
        .i_qvec  (r_qvec),
        .i_tag   (w_tag_in),
        .o_tag   (w_tag_out),
        .o_dist  (w_dist)
    );

    // query sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (w_last_step) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_tag_out.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (w_shift) begin
                r_step <= w_last_step ? '0 : r_step + 1'b1;
            end
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    // query index and query vector capture
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_q <= i_query_index;
        end
        if ((r_state == S_FETCH) && (w_step_x == w_q_x)) begin
            r_qvec <= w_cell[0].comp;
        end
    end

    // running nearest candidate, lower index kept on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_query) begin
            r_found <= 1'b0;
        end else if (w_tag_out.valid && (!r_found || (w_dist < r_best_d))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag_out.valid && (!r_found || (w_dist < r_best_d))) begin
            r_best_idx <= w_tag_out.idx;
            r_best_d   <= w_dist;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_found <= r_found;
            r_out_idx   <= r_found ? w_best_x[mnps_pkg::OUT_IDX_W-1:0] : '0;
            r_out_dist  <= r_found ? mnps_pkg::OUT_DIST_W'(r_best_d) : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_out_found;
    assign o_best_index       = r_out_idx;
    assign o_best_distance_sq = r_out_dist;

endmodule

@@ test/tb.sv @@
// tb: self-checking bench for masked_nearest_pose_search, loads the pose table and runs searches
// depends on mnps_pkg and the masked_nearest_pose_search rtl; results checked against an
// in-bench nearest-candidate predictor, with random idling on both channels
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASE_ITEMS   = 160;

    // one input transaction as the bench sees it
    typedef struct packed {
        logic           kind;
        logic [5:0]     slot;
        mnps_pkg::t_vec comp;
        logic           cand;
        logic [5:0]     qidx;
    } t_pose_item;

    typedef struct packed {
        logic        found;
        logic [5:0]  idx;
        logic [36:0] dist_sq;
    } t_search_result;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // block ports
    logic                                 i_in_valid     = 1'b0;
    logic                                 o_in_stall;
    logic                                 i_kind         = mnps_pkg::KIND_LOAD;
    logic [5:0]                           i_entry_index  = '0;
    logic signed [mnps_pkg::COMP_W-1:0]   i_pos_x        = '0;
    logic signed [mnps_pkg::COMP_W-1:0]   i_pos_y        = '0;
    logic signed [mnps_pkg::COMP_W-1:0]   i_pos_z        = '0;
    logic signed [mnps_pkg::COMP_W-1:0]   i_dir_x        = '0;
    logic signed [mnps_pkg::COMP_W-1:0]   i_dir_y        = '0;
    logic signed [mnps_pkg::COMP_W-1:0]   i_dir_z        = '0;
    logic                                 i_is_candidate = 1'b0;
    logic [5:0]                           i_query_index  = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall    = 1'b0;
    logic                                 o_found;
    logic [mnps_pkg::OUT_IDX_W-1:0]       o_best_index;
    logic [mnps_pkg::OUT_DIST_W-1:0]      o_best_distance_sq;
    logic                                 i_cfg_valid    = 1'b0;
    logic                                 o_cfg_ready;
    logic [mnps_pkg::COUNT_W-1:0]         i_cfg_data     = '0;

    // predictor state
    mnps_pkg::t_vec pose_table [mnps_pkg::MAX_ENTRIES];
    logic           cand_table [mnps_pkg::MAX_ENTRIES];
    int             search_count = 0;
    t_search_result pending_results [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int rcv_hold       = 0;
    bit idle_on        = 1'b0;

    masked_nearest_pose_search DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_entry_index      (i_entry_index),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_pos_z            (i_pos_z),
        .i_dir_x            (i_dir_x),
        .i_dir_y            (i_dir_y),
        .i_dir_z            (i_dir_z),
        .i_is_candidate     (i_is_candidate),
        .i_query_index      (i_query_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_found            (o_found),
        .o_best_index       (o_best_index),
        .o_best_distance_sq (o_best_distance_sq),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // nearest candidate other than the query, squared distance exact, lower index on ties
    function automatic t_search_result nearest_candidate(input logic [5:0] q);
        t_search_result r;
        int             eff;
        int             diff;
        longint         sum;
        longint         best_d;
        r      = '0;
        best_d = 0;
        eff    = (search_count > mnps_pkg::MAX_ENTRIES) ? mnps_pkg::MAX_ENTRIES : search_count;
        if (int'(q) < eff) begin
            for (int i = 0; i < eff; i++) begin
                if (i == int'(q) || !cand_table[i]) continue;
                sum = 0;
                for (int k = 0; k < mnps_pkg::NCOMP; k++) begin
                    diff = int'($signed(pose_table[i][k])) - int'($signed(pose_table[q][k]));
                    sum += longint'(diff) * longint'(diff);
                end
                if (!r.found || sum < best_d) begin
                    r.found = 1'b1;
                    r.idx   = i[5:0];
                    best_d  = sum;
                end
            end
        end
        if (r.found) r.dist_sq = best_d[36:0];
        return r;
    endfunction

    function automatic logic [15:0] random_comp();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // every field random, callers override what matters
    function automatic t_pose_item random_fields();
        t_pose_item it;
        it.kind = 1'($urandom());
        it.slot = 6'($urandom());
        for (int k = 0; k < mnps_pkg::NCOMP; k++) it.comp[k] = 16'($urandom());
        it.cand = 1'($urandom());
        it.qidx = 6'($urandom());
        return it;
    endfunction

    function automatic t_pose_item load_item(input logic [5:0] slot,
                                             input mnps_pkg::t_vec comp,
                                             input logic cand);
        t_pose_item it;
        it      = random_fields();
        it.kind = mnps_pkg::KIND_LOAD;
        it.slot = slot;
        it.comp = comp;
        it.cand = cand;
        return it;
    endfunction

    function automatic t_pose_item query_item(input logic [5:0] q);
        t_pose_item it;
        it      = random_fields();
        it.kind = mnps_pkg::KIND_QUERY;
        it.qidx = q;
        return it;
    endfunction

    function automatic mnps_pkg::t_vec uniform_vec(input logic [15:0] v);
        mnps_pkg::t_vec c;
        for (int k = 0; k < mnps_pkg::NCOMP; k++) c[k] = v;
        return c;
    endfunction

    // random load or query; loads often copy a stored pose so ties and near ties occur
    function automatic t_pose_item random_item();
        t_pose_item     it;
        mnps_pkg::t_vec c;
        int             eff;
        int             k;
        if ($urandom_range(0, 99) < 45) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: for (int j = 0; j < mnps_pkg::NCOMP; j++) c[j] = random_comp();
                5, 6, 7: begin
                    c = pose_table[$urandom_range(0, mnps_pkg::MAX_ENTRIES - 1)];
                    k = $urandom_range(0, mnps_pkg::NCOMP - 1);
                    c[k] = c[k] + 16'($urandom_range(0, 2)) - 16'd1;
                end
                default: for (int j = 0; j < mnps_pkg::NCOMP; j++) c[j] = 16'($urandom());
            endcase
            it = load_item(6'($urandom()), c, $urandom_range(0, 9) < 7);
        end else begin
            eff = (search_count > mnps_pkg::MAX_ENTRIES) ? mnps_pkg::MAX_ENTRIES : search_count;
            if (eff > 0 && $urandom_range(0, 5) != 0)
                it = query_item(6'($urandom_range(0, eff - 1)));
            else
                it = query_item(6'($urandom()));
        end
        return it;
    endfunction

    // drive one transaction, hold it while stalled, update the predictor on acceptance
    task automatic send_item(input t_pose_item it);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= it.kind;
        i_entry_index  <= it.slot;
        i_pos_x        <= it.comp[0];
        i_pos_y        <= it.comp[1];
        i_pos_z        <= it.comp[2];
        i_dir_x        <= it.comp[3];
        i_dir_y        <= it.comp[4];
        i_dir_z        <= it.comp[5];
        i_is_candidate <= it.cand;
        i_query_index  <= it.qidx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (it.kind == mnps_pkg::KIND_LOAD) begin
            pose_table[it.slot] = it.comp;
            cand_table[it.slot] = it.cand;
        end else begin
            pending_results = {pending_results, nearest_candidate(it.qidx)};
        end
    endtask

    // drain all searches, then allow for a search still in flight
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= 7'(value);
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid  <= 1'b0;
        search_count = value & 127;
    endtask

    // searches with the reset count of zero touch no entry
    task automatic test_empty_table();
        send_item(query_item(6'd0));
        send_item(query_item(6'd63));
        wait_idle();
    endtask

    // small table: extremes, alternating bit patterns, tie, self exclusion, out of range
    task automatic test_small_table();
        mnps_pkg::t_vec c;
        t_pose_item     fill_a;
        t_pose_item     fill_b;
        fill_a = random_fields();
        fill_b = random_fields();
        write_count(8);
        send_item(load_item(6'd0, uniform_vec(16'h7FFF), 1'b0));
        send_item(load_item(6'd1, uniform_vec(16'h8000), 1'b1));
        send_item(load_item(6'd2, uniform_vec(16'h0000), 1'b1));
        send_item(load_item(6'd3, uniform_vec(16'h0000), 1'b1));
        for (int k = 0; k < mnps_pkg::NCOMP; k++) c[k] = (k % 2) ? 16'h5555 : 16'hAAAA;
        send_item(load_item(6'd4, c, 1'b0));
        send_item(load_item(6'd5, fill_a.comp, 1'b1));
        send_item(load_item(6'd6, ~c, 1'b1));
        send_item(load_item(6'd7, fill_b.comp, 1'b1));
        send_item(query_item(6'd0));
        send_item(query_item(6'd1));
        send_item(query_item(6'd2));
        send_item(query_item(6'd3));
        send_item(query_item(6'd4));
        send_item(query_item(6'd7));
        send_item(query_item(6'd8));
        send_item(query_item(6'd63));
        wait_idle();
    endtask

    // tiny counts: largest distance, only the query itself, nothing in range
    task automatic test_count_edges();
        write_count(2);
        send_item(query_item(6'd0));
        send_item(query_item(6'd1));
        wait_idle();
        write_count(1);
        send_item(query_item(6'd0));
        wait_idle();
        write_count(0);
        send_item(query_item(6'd0));
        wait_idle();
    endtask

    // write every slot so that any count may be searched from here on
    task automatic test_fill_table();
        mnps_pkg::t_vec c;
        for (int s = 0; s < mnps_pkg::MAX_ENTRIES; s++) begin
            for (int k = 0; k < mnps_pkg::NCOMP; k++) c[k] = random_comp();
            send_item(load_item(6'(s), c, 1'($urandom())));
        end
    endtask

    task automatic test_random_phase(input int count, input bit idling);
        wait_idle();
        write_count(count);
        idle_on = idling;
        repeat (PHASE_ITEMS) send_item(random_item());
    endtask

    // result side stall in random bursts
    always @(posedge i_clk) begin
        if (rcv_hold > 0) begin
            i_out_stall <= 1'b1;
            rcv_hold--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            rcv_hold = $urandom_range(0, 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_search_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected, index %0d", o_best_index));
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found)
                    report_mismatch($sformatf("found %b, want %b", o_found, want.found));
                if (o_best_index !== want.idx)
                    report_mismatch($sformatf("best_index %0d, want %0d", o_best_index, want.idx));
                if (o_best_distance_sq !== want.dist_sq)
                    report_mismatch($sformatf("best_distance_sq %0d, want %0d",
                                              o_best_distance_sq, want.dist_sq));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // test sequence
    initial begin
        for (int s = 0; s < mnps_pkg::MAX_ENTRIES; s++) begin
            pose_table[s] = '0;
            cand_table[s] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        test_empty_table();
        test_small_table();
        test_count_edges();
        test_fill_table();
        test_random_phase(64, 1'b1);
        test_random_phase(127, 1'b1);
        test_random_phase(2, 1'b1);
        test_random_phase($urandom_range(3, 63), 1'b1);
        test_random_phase($urandom_range(65, 126), 1'b1);
        test_random_phase(64, 1'b0);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
